// File: design/pbrd_pkg.sv
// Shared types and constants for the PackBits row decoder.
// No dependencies; every other design file but pbrd_queue refers to it by scoped names.
`default_nettype none

package pbrd_pkg;

  // Header byte boundary of the ByteRun1 scheme.
  localparam logic [7:0] HDR_NOP = 8'h80;

  // Widest bitplane row the decoder honors, and the saturation value of the byte count.
  localparam logic [10:0] MAX_ROW_BYTES = 11'd1024;
  localparam logic [10:0] COUNT_MAX     = 11'h7ff;

  // Largest number of bitplanes in one image row.
  localparam logic [3:0] MAX_PLANES = 4'd8;

  // Configuration register indexes.
  localparam logic CFG_ROW_BYTES      = 1'b0;
  localparam logic CFG_PLANES_PER_ROW = 1'b1;

  // What the front end expects next from the compressed stream.
  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_LITERAL,
    MODE_REPEAT
  } mode_t;

  // One command from the front end to the back end: a byte emitted len times.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] len;
    logic       eop;
    logic       eor;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/packbits_row_decoder.sv
// Top level of the PackBits (ByteRun1) row decoder.
// Depends on pbrd_pkg, pbrd_front, pbrd_queue and pbrd_back.
//
// Usage:
//   The input channel (in_valid, in_byte, in_stall) takes one compressed byte
//   per beat. The output channel (out_valid, out_stall and the result fields)
//   delivers decoded bytes, one or two per beat, with end_of_plane and
//   end_of_row flags on the last beat of a packet that completes a plane.
//   Registers row_bytes (index 0) and planes_per_row (index 1) are written
//   through cfg_we, cfg_index and cfg_data while the decoder is idle.
//   A data byte passes through the command queue, the back-end work register
//   and the output register before its beat shows. Header bytes yield no beat.
//   Throughput: one compressed byte per cycle for literals; the back end
//   expands a run two bytes per beat, and the input stalls once the
//   four-entry command queue is full.
//   Reset clears the parser, the plane counters and the queue, and loads
//   row_bytes = 40 and planes_per_row = 4. When the receiver stalls, the
//   output beat holds, the back end stops, and the queue fills until the
//   input stalls as well.
`default_nettype none

module packbits_row_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       byte_a,
  output logic [7:0]       byte_b,
  output logic [1:0]       valid_bytes,
  output logic             end_of_plane,
  output logic             end_of_row
);

  localparam int QDEPTH = 4;

  logic [10:0] row_bytes;
  logic [3:0]  planes_per_row;

  pbrd_pkg::cmd_t front_cmd;
  pbrd_pkg::cmd_t back_cmd;
  logic [$bits(pbrd_pkg::cmd_t)-1:0] q_rdata;
  logic           push, pop, q_full, q_empty;
  logic           accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes      <= 11'd40;
      planes_per_row <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pbrd_pkg::CFG_ROW_BYTES:      row_bytes      <= cfg_data;
        pbrd_pkg::CFG_PLANES_PER_ROW: planes_per_row <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign back_cmd = pbrd_pkg::cmd_t'(q_rdata);

  pbrd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .in_byte        (in_byte),
    .row_bytes      (row_bytes),
    .planes_per_row (planes_per_row),
    .cmd            (front_cmd),
    .push           (push)
  );

  pbrd_queue #(
    .WIDTH ($bits(pbrd_pkg::cmd_t)),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .pop   (pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  pbrd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_cmd        (back_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_a       (byte_a),
    .byte_b       (byte_b),
    .valid_bytes  (valid_bytes),
    .end_of_plane (end_of_plane),
    .end_of_row   (end_of_row)
  );

endmodule

`default_nettype wire

// File: design/pbrd_front.sv
// Front end of the PackBits row decoder: parses headers, counts plane bytes
// and issues byte commands. Depends on pbrd_pkg.
`default_nettype none

module pbrd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic [10:0]     row_bytes,
  input  wire logic [3:0]      planes_per_row,
  output pbrd_pkg::cmd_t       cmd,
  output logic                 push
);

  pbrd_pkg::mode_t mode, mode_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [10:0] plane_byte_count, plane_byte_count_next;
  logic [2:0]  plane_index, plane_index_next;

  logic [7:0]  add_len;
  logic [11:0] count_sum;
  logic [10:0] count_sat;
  logic [10:0] width_eff;
  logic [3:0]  planes_eff;
  logic        plane_done;
  logic        row_done;
  logic        finish;

  // Effective row width and plane count after clamping.
  assign width_eff = (row_bytes > pbrd_pkg::MAX_ROW_BYTES) ? pbrd_pkg::MAX_ROW_BYTES
                                                           : row_bytes;
  always_comb begin
    priority if (planes_per_row == 4'd0) begin
      planes_eff = 4'd1;
    end else if (planes_per_row > pbrd_pkg::MAX_PLANES) begin
      planes_eff = pbrd_pkg::MAX_PLANES;
    end else begin
      planes_eff = planes_per_row;
    end
  end

  // Bytes this beat adds to the plane count, with saturation.
  assign add_len   = (mode == pbrd_pkg::MODE_REPEAT) ? bytes_left : 8'd1;
  assign count_sum = {1'b0, plane_byte_count} + {4'b0, add_len};
  assign count_sat = count_sum[11] ? pbrd_pkg::COUNT_MAX : count_sum[10:0];

  // A packet ends on the last literal byte or on the byte of a run.
  assign finish     = (mode == pbrd_pkg::MODE_REPEAT) ||
                      ((mode == pbrd_pkg::MODE_LITERAL) && (bytes_left <= 8'd1));
  assign plane_done = finish && (count_sat >= width_eff);
  assign row_done   = plane_done && (({1'b0, plane_index} + 4'd1) >= planes_eff);

  // Next packet mode.
  always_comb begin
    mode_next = mode;
    if (accept) begin
      unique case (mode)
        pbrd_pkg::MODE_HEADER: begin
          if (in_byte < pbrd_pkg::HDR_NOP) begin
            mode_next = pbrd_pkg::MODE_LITERAL;
          end else if (in_byte > pbrd_pkg::HDR_NOP) begin
            mode_next = pbrd_pkg::MODE_REPEAT;
          end else begin
            mode_next = pbrd_pkg::MODE_HEADER;
          end
        end
        pbrd_pkg::MODE_LITERAL: begin
          mode_next = finish ? pbrd_pkg::MODE_HEADER : pbrd_pkg::MODE_LITERAL;
        end
        pbrd_pkg::MODE_REPEAT: begin
          mode_next = pbrd_pkg::MODE_HEADER;
        end
        default: begin
          mode_next = pbrd_pkg::MODE_HEADER;
        end
      endcase
    end
  end

  // Counters and the command pushed for each data byte.
  always_comb begin
    bytes_left_next       = bytes_left;
    plane_byte_count_next = plane_byte_count;
    plane_index_next      = plane_index;
    push                  = 1'b0;
    cmd.data              = in_byte;
    cmd.len               = add_len;
    cmd.eop               = plane_done;
    cmd.eor               = row_done;
    if (accept) begin
      if (mode == pbrd_pkg::MODE_HEADER) begin
        if (in_byte < pbrd_pkg::HDR_NOP) begin
          bytes_left_next = in_byte + 8'd1;
        end else if (in_byte > pbrd_pkg::HDR_NOP) begin
          bytes_left_next = (~in_byte) + 8'd2;
        end else begin
          bytes_left_next = 8'd0;
        end
      end else begin
        push = 1'b1;
        bytes_left_next = finish ? 8'd0 : (bytes_left - 8'd1);
        if (plane_done) begin
          plane_byte_count_next = 11'd0;
          plane_index_next      = row_done ? 3'd0 : (plane_index + 3'd1);
        end else begin
          plane_byte_count_next = count_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= pbrd_pkg::MODE_HEADER;
      bytes_left       <= 8'd0;
      plane_byte_count <= 11'd0;
      plane_index      <= 3'd0;
    end else begin
      mode             <= mode_next;
      bytes_left       <= bytes_left_next;
      plane_byte_count <= plane_byte_count_next;
      plane_index      <= plane_index_next;
    end
  end

  // A data byte always arrives with a nonzero count still owed.
  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    (mode != pbrd_pkg::MODE_HEADER) |-> (bytes_left != 8'd0))
    else $error("packet in progress with no bytes left");

endmodule

`default_nettype wire

// File: design/pbrd_queue.sv
// Small register FIFO that decouples the decoder's front and back ends.
// No dependencies.
`default_nettype none

module pbrd_queue #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == FULL_CNT);
  assign empty = (fill == '0);
  assign rdata = mem[rd_ptr];

  // Storage; entries need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("read from an empty queue");

endmodule

`default_nettype wire

// File: design/pbrd_back.sv
// Back end of the PackBits row decoder: expands byte commands into
// one- or two-byte result beats behind an output register. Depends on pbrd_pkg.
`default_nettype none

module pbrd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire pbrd_pkg::cmd_t q_cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          byte_a,
  output logic [7:0]          byte_b,
  output logic [1:0]          valid_bytes,
  output logic                end_of_plane,
  output logic                end_of_row
);

  logic       work_valid, work_valid_next;
  logic [7:0] work_rem, work_rem_next;
  logic [7:0] work_data;
  logic       work_eop, work_eor;

  logic       emit;
  logic       two;
  logic       last;

  // One beat per cycle while the output register is free.
  assign emit = work_valid && (!out_valid || !out_stall);
  assign two  = (work_rem >= 8'd2);
  assign last = (work_rem <= 8'd2);
  assign pop  = !q_empty && (!work_valid || (emit && last));

  always_comb begin
    work_valid_next = work_valid;
    work_rem_next   = work_rem;
    if (pop) begin
      work_valid_next = 1'b1;
      work_rem_next   = q_cmd.len;
    end else if (emit) begin
      work_valid_next = !last;
      work_rem_next   = work_rem - (two ? 8'd2 : 8'd1);
    end
  end

  // Current command.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else begin
      work_valid <= work_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    work_rem <= work_rem_next;
    if (pop) begin
      work_data <= q_cmd.data;
      work_eop  <= q_cmd.eop;
      work_eor  <= q_cmd.eor;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_a       <= work_data;
      byte_b       <= two ? work_data : 8'd0;
      valid_bytes  <= two ? 2'd2 : 2'd1;
      end_of_plane <= last && work_eop;
      end_of_row   <= last && work_eor;
    end
  end

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> (work_rem != 8'd0))
    else $error("active command with nothing left to emit");

  a_row_implies_plane: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_row) |-> end_of_plane)
    else $error("row end without plane end");

endmodule

`default_nettype wire

// File: bench/pbrd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the PackBits row decoder: it mirrors the decoder state from the
// accepted compressed bytes and register writes, and compares every output beat.
// Depends on pbrd_pkg for the parser mode enum, the register indexes and limits.

module pbrd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  byte_a,
  input  logic [7:0]  byte_b,
  input  logic [1:0]  valid_bytes,
  input  logic        end_of_plane,
  input  logic        end_of_row,
  output int          pending,
  output int          errors
);

  // One decoded output beat as the decoder should present it.
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] count;
    logic       plane_end;
    logic       row_end;
  } beat_t;

  beat_t decoded_q[$];

  // Mirrored registers and parser state.
  logic [10:0]     row_width;
  logic [3:0]      plane_total;
  pbrd_pkg::mode_t mode;
  logic [7:0]      bytes_left;
  logic [10:0]     plane_bytes;
  logic [2:0]      plane_idx;

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    errors = errors + 1;
  endtask

  // The byte count of a plane saturates rather than wrapping.
  task automatic add_bytes(input logic [7:0] n);
    logic [11:0] sum;
    sum = {1'b0, plane_bytes} + {4'b0, n};
    plane_bytes = (sum > {1'b0, pbrd_pkg::COUNT_MAX}) ? pbrd_pkg::COUNT_MAX : sum[10:0];
  endtask

  // A packet has completed: decide whether it closed a plane and a row.
  task automatic close_packet(output logic eop, output logic eor);
    logic [10:0] width;
    logic [3:0]  planes;
    width = (row_width > pbrd_pkg::MAX_ROW_BYTES) ? pbrd_pkg::MAX_ROW_BYTES : row_width;
    if (plane_total == 4'd0) planes = 4'd1;
    else if (plane_total > pbrd_pkg::MAX_PLANES) planes = pbrd_pkg::MAX_PLANES;
    else planes = plane_total;
    eop = 1'b0;
    eor = 1'b0;
    mode = pbrd_pkg::MODE_HEADER;
    bytes_left = 8'd0;
    if (plane_bytes >= width) begin
      eop = 1'b1;
      plane_bytes = 11'd0;
      if ({1'b0, plane_idx} + 4'd1 >= planes) begin
        eor = 1'b1;
        plane_idx = 3'd0;
      end else begin
        plane_idx = plane_idx + 3'd1;
      end
    end
  endtask

  // Expand one compressed byte into the beats it causes.
  task automatic expand_byte(input logic [7:0] b);
    beat_t      beat;
    logic       eop;
    logic       eor;
    logic [7:0] n;
    logic [1:0] k;
    if (mode == pbrd_pkg::MODE_LITERAL && bytes_left != 8'd0) begin
      add_bytes(8'd1);
      bytes_left = bytes_left - 8'd1;
      eop = 1'b0;
      eor = 1'b0;
      if (bytes_left == 8'd0) close_packet(eop, eor);
      beat.first = b;
      beat.second = 8'h00;
      beat.count = 2'd1;
      beat.plane_end = eop;
      beat.row_end = eor;
      decoded_q.push_back(beat);
    end else if (mode == pbrd_pkg::MODE_REPEAT && bytes_left != 8'd0) begin
      // The whole run is counted at once; flags ride on its last beat.
      n = bytes_left;
      add_bytes(n);
      close_packet(eop, eor);
      while (n != 8'd0) begin
        k = (n >= 8'd2) ? 2'd2 : 2'd1;
        n = n - {6'b0, k};
        beat.first = b;
        beat.second = (k == 2'd2) ? b : 8'h00;
        beat.count = k;
        beat.plane_end = (n == 8'd0) ? eop : 1'b0;
        beat.row_end = (n == 8'd0) ? eor : 1'b0;
        decoded_q.push_back(beat);
      end
    end else if (b < pbrd_pkg::HDR_NOP) begin
      mode = pbrd_pkg::MODE_LITERAL;
      bytes_left = b + 8'd1;
    end else if (b > pbrd_pkg::HDR_NOP) begin
      mode = pbrd_pkg::MODE_REPEAT;
      bytes_left = (b ^ 8'hff) + 8'd2;
    end else begin
      mode = pbrd_pkg::MODE_HEADER;
      bytes_left = 8'd0;
    end
  endtask

  // Output beats are checked before new bytes are predicted in the same cycle.
  always @(posedge clk) begin : watch
    beat_t want;
    if (rst) begin
      decoded_q.delete();
      row_width = 11'd40;
      plane_total = 4'd4;
      mode = pbrd_pkg::MODE_HEADER;
      bytes_left = 8'd0;
      plane_bytes = 11'd0;
      plane_idx = 3'd0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          flag_mismatch("beat with nothing expected, byte_a", 0, byte_a);
        end else begin
          want = decoded_q.pop_front();
          if (byte_a !== want.first) flag_mismatch("byte_a", want.first, byte_a);
          if (byte_b !== want.second) flag_mismatch("byte_b", want.second, byte_b);
          if (valid_bytes !== want.count) flag_mismatch("valid_bytes", want.count, valid_bytes);
          if (end_of_plane !== want.plane_end) begin
            flag_mismatch("end_of_plane", want.plane_end, end_of_plane);
          end
          if (end_of_row !== want.row_end) flag_mismatch("end_of_row", want.row_end, end_of_row);
        end
      end
      if (cfg_we) begin
        if (cfg_index == pbrd_pkg::CFG_ROW_BYTES) row_width = cfg_data;
        else plane_total = cfg_data[3:0];
      end
      if (in_valid && !in_stall) expand_byte(in_byte);
    end
    pending <= decoded_q.size();
  end

endmodule

// File: bench/packbits_row_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench top for the PackBits row decoder: drives compressed byte streams and
// register settings, stalls the output at random and gives the verdict.
// Depends on pbrd_pkg, packbits_row_decoder and pbrd_checker.

module packbits_row_decoder_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = 11'd0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'd0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  byte_a;
  logic [7:0]  byte_b;
  logic [1:0]  valid_bytes;
  logic        end_of_plane;
  logic        end_of_row;
  int          pending;
  int          errors;
  bit          calm = 1'b0;
  int          items_sent = 0;

  packbits_row_decoder DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .byte_a(byte_a), .byte_b(byte_b), .valid_bytes(valid_bytes),
    .end_of_plane(end_of_plane), .end_of_row(end_of_row)
  );

  pbrd_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .byte_a(byte_a), .byte_b(byte_b), .valid_bytes(valid_bytes),
    .end_of_plane(end_of_plane), .end_of_row(end_of_row),
    .pending(pending), .errors(errors)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the decoder hangs.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // The receiver stalls in short random bursts until the calm part of the run.
  initial begin : receiver_stalls
    int burst;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one compressed byte, possibly after a short gap, and wait until it is accepted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent = items_sent + 1;
  endtask

  // Literal packet of len bytes, 1 to 128.
  task automatic send_literal(input int len);
    logic [7:0] hdr;
    hdr = 8'(len - 1);
    send_byte(hdr);
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Run packet repeating one byte count times, 2 to 128.
  task automatic send_run(input int count, input logic [7:0] data);
    logic [8:0] hdr;
    hdr = 9'(257 - count);
    send_byte(hdr[7:0]);
    send_byte(data);
  endtask

  // Mostly well-formed packets with random content, plus no-ops and stray bytes.
  task automatic send_random_packet();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 19) == 0) send_literal($urandom_range(9, 128));
      else send_literal($urandom_range(1, 8));
    end else if (pick < 85) begin
      send_run($urandom_range(2, 128), 8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      send_byte(pbrd_pkg::HDR_NOP);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Hold the input until every expected beat is out and the pipeline has drained.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  // Write both registers; the upper bits of the plane count write are junk.
  task automatic load_settings(input logic [10:0] width, input logic [3:0] planes);
    logic [6:0] junk;
    junk = 7'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= pbrd_pkg::CFG_ROW_BYTES;
    cfg_data <= width;
    @(posedge clk);
    cfg_index <= pbrd_pkg::CFG_PLANES_PER_ROW;
    cfg_data <= {junk, planes};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [10:0] width, input logic [3:0] planes,
                           input int quota);
    int target;
    settle();
    load_settings(width, planes);
    target = items_sent + quota;
    while (items_sent < target) send_random_packet();
  endtask

  initial begin : stimulus
    logic [10:0] width;
    logic [3:0]  planes;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings: no-op header, extreme bytes, short
    // literals, the shortest and longest runs, an odd-length run, and a full row.
    send_byte(pbrd_pkg::HDR_NOP);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h5a);
    send_run(2, 8'h00);
    send_run(128, 8'hff);
    send_run(3, 8'ha5);
    send_byte(8'h02);
    send_byte(8'h01);
    send_byte(pbrd_pkg::HDR_NOP);
    send_byte(8'h7f);
    repeat (3) send_run(128, 8'($urandom_range(0, 255)));

    // Zero row width: every packet ends a plane, one plane per row.
    run_phase(11'd0, 4'd1, 25);
    // One-byte planes with the most planes per row.
    run_phase(11'd1, 4'd8, 25);
    // The widest plane, filled exactly by eight long runs.
    run_phase(11'd1024, 4'd2, 0);
    repeat (8) send_run(128, 8'($urandom_range(0, 255)));
    while (items_sent < 130) send_random_packet();
    // Register values beyond the limits act as the limits.
    run_phase(11'd2047, 4'd15, 25);
    run_phase(11'd5, 4'd8, 25);
    // Plane count lowered mid-row, and a zero plane count.
    run_phase(11'd5, 4'd0, 20);

    // Final stretch with no idling on either side.
    width = 11'($urandom_range(1, 64));
    planes = 4'($urandom_range(1, 8));
    settle();
    calm = 1'b1;
    run_phase(width, planes, 40);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
